>>> hw/rtl/led_matrix_grid_mapper_assert.svh
// assertion macros for the led matrix grid mapper
`ifndef LED_MATRIX_GRID_MAPPER_ASSERT_SVH
`define LED_MATRIX_GRID_MAPPER_ASSERT_SVH

// checked property, ignored while reset is low
`define LMGM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked property, also during reset
`define LMGM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hw/rtl/lmgm_pkg.sv
// shared types, codes and helpers of the led matrix grid mapper
`default_nettype none

package lmgm_pkg;

  localparam int unsigned MAX_TILE_ROWS = 4;
  localparam int unsigned MAX_TILE_COLS = 8;

  typedef enum logic [1:0] {
    OP_LED  = 2'd0,
    OP_ROW  = 2'd1,
    OP_COL  = 2'd2,
    OP_RSVD = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_LED = 2'd0,
    KIND_ROW = 2'd1,
    KIND_COL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_NUM_ROWS = 2'd0,
    CFG_NUM_COLS = 2'd1,
    CFG_ROT_MAP  = 2'd2
  } cfg_idx_e;

  // one per-tile beat on its way through the pipeline
  typedef struct packed {
    logic       vld;
    logic       err;
    opcode_e    op;
    logic [4:0] tile;
    logic [2:0] r;
    logic [2:0] c;
    logic       led;
    logic [7:0] pat;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [4:0] tile;
    kind_e      kind;
    logic [2:0] line;
    logic [2:0] bit_sel;
    logic [7:0] pat;
    logic       err;
    logic       last;
  } result_t;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lmgm_rotate.sv
// per-tile rotation: local line, bit and data byte of one beat
`default_nettype none

module lmgm_rotate (
  input  lmgm_pkg::beat_t   beat_i,
  input  logic [1:0]        rot_i,
  output lmgm_pkg::result_t res_o
);

  logic [7:0] pat_rev;

  assign pat_rev = lmgm_pkg::rev8(beat_i.pat);

  always_comb begin
    res_o = '0;
    res_o.last = beat_i.last;
    if (beat_i.err) begin
      res_o.err  = 1'b1;
      res_o.last = 1'b1;
    end else begin
      res_o.tile = beat_i.tile;
      case (beat_i.op)
        lmgm_pkg::OP_LED: begin
          res_o.kind = lmgm_pkg::KIND_LED;
          res_o.pat  = {7'b0, beat_i.led};
          case (rot_i)
            2'd0: begin res_o.line = beat_i.r;  res_o.bit_sel = beat_i.c;  end
            2'd1: begin res_o.line = ~beat_i.c; res_o.bit_sel = beat_i.r;  end
            2'd2: begin res_o.line = ~beat_i.r; res_o.bit_sel = ~beat_i.c; end
            default: begin res_o.line = beat_i.c; res_o.bit_sel = ~beat_i.r; end
          endcase
        end
        lmgm_pkg::OP_ROW: begin
          case (rot_i)
            2'd0: begin
              res_o.kind = lmgm_pkg::KIND_ROW; res_o.line = beat_i.r;  res_o.pat = beat_i.pat;
            end
            2'd1: begin
              res_o.kind = lmgm_pkg::KIND_COL; res_o.line = beat_i.r;  res_o.pat = pat_rev;
            end
            2'd2: begin
              res_o.kind = lmgm_pkg::KIND_ROW; res_o.line = ~beat_i.r; res_o.pat = pat_rev;
            end
            default: begin
              res_o.kind = lmgm_pkg::KIND_COL; res_o.line = ~beat_i.r; res_o.pat = beat_i.pat;
            end
          endcase
        end
        lmgm_pkg::OP_COL: begin
          case (rot_i)
            2'd0: begin
              res_o.kind = lmgm_pkg::KIND_COL; res_o.line = beat_i.c;  res_o.pat = beat_i.pat;
            end
            2'd1: begin
              res_o.kind = lmgm_pkg::KIND_ROW; res_o.line = ~beat_i.c; res_o.pat = beat_i.pat;
            end
            2'd2: begin
              res_o.kind = lmgm_pkg::KIND_COL; res_o.line = ~beat_i.c; res_o.pat = pat_rev;
            end
            default: begin
              res_o.kind = lmgm_pkg::KIND_ROW; res_o.line = beat_i.c;  res_o.pat = pat_rev;
            end
          endcase
        end
        default: begin
          res_o.err  = 1'b1;
          res_o.last = 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/led_matrix_grid_mapper.sv
// top level: serpentine led matrix grid mapper
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------------
//  command   | start_i / busy_o          | opcode, row_index, col_index, led_on, line_bytes
//  config    | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//  result    | result_valid_o (strobe)   | tile_number .. last_of_run
//
// a command is taken when start_i is high and busy_o is low
// a single led command or an error gives one beat, a row write num_col_devices beats
// and a column write num_row_devices beats, one beat a cycle from the sequencer
// busy_o drops in the cycle of the last beat, so one-beat commands go back to back
// and line writes give 1 to 8 beats; the first result strobe passes the sequencer,
// tile address, rotation lookup and output register after the take; no receiver stall
`default_nettype none

module led_matrix_grid_mapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [4:0]  row_index_i,
  input  logic [5:0]  col_index_i,
  input  logic        led_on_i,
  input  logic [63:0] line_bytes_i,
  // config channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // result channel
  output logic        result_valid_o,
  output logic [4:0]  tile_number_o,
  output logic [1:0]  command_kind_o,
  output logic [2:0]  line_select_o,
  output logic [2:0]  bit_select_o,
  output logic [7:0]  pattern_byte_o,
  output logic        out_of_range_o,
  output logic        last_of_run_o
);

  // config registers
  logic [2:0]  num_rows_q;
  logic [3:0]  num_cols_q;
  logic [63:0] rot_map_q;

  // sequencer registers
  logic                  seq_vld_q;
  lmgm_pkg::opcode_e     op_q;
  logic [4:0]            row_q;
  logic [5:0]            col_q;
  logic                  led_q;
  logic [63:0]           bytes_q;
  logic [2:0]            idx_q;

  // pipeline stages
  lmgm_pkg::beat_t   beat_a_d, beat_a_q, beat_b_q;
  logic [1:0]        rot_b_q;
  lmgm_pkg::result_t res_d;
  logic              res_vld_q;
  lmgm_pkg::result_t res_q;

  // clamped grid size
  logic [2:0] nr;
  logic [3:0] nc;
  logic       seq_err;
  logic [2:0] beats_m1;
  logic       last_beat;
  logic       accept;

  // tile address
  logic [1:0] rb;
  logic [2:0] cb;
  logic [2:0] cpos;
  logic [4:0] tile_base;

  // result beat checks
  logic       err_beat_clean;
  logic       led_beat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= 3'd1;
      num_cols_q <= 4'd1;
      rot_map_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lmgm_pkg::CFG_NUM_ROWS: num_rows_q <= cfg_data_i[2:0];
        lmgm_pkg::CFG_NUM_COLS: num_cols_q <= cfg_data_i[3:0];
        lmgm_pkg::CFG_ROT_MAP:  rot_map_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero counts as one, large values saturate
  always_comb begin
    if (num_rows_q == 3'd0) begin
      nr = 3'd1;
    end else if (num_rows_q > 3'(lmgm_pkg::MAX_TILE_ROWS)) begin
      nr = 3'(lmgm_pkg::MAX_TILE_ROWS);
    end else begin
      nr = num_rows_q;
    end
    if (num_cols_q == 4'd0) begin
      nc = 4'd1;
    end else if (num_cols_q > 4'(lmgm_pkg::MAX_TILE_COLS)) begin
      nc = 4'(lmgm_pkg::MAX_TILE_COLS);
    end else begin
      nc = num_cols_q;
    end
  end

  // range check and beat count of the held command
  always_comb begin
    seq_err = 1'b0;
    case (op_q)
      lmgm_pkg::OP_LED: seq_err = ({1'b0, row_q[4:3]} >= nr) || ({1'b0, col_q[5:3]} >= nc);
      lmgm_pkg::OP_ROW: seq_err = ({1'b0, row_q[4:3]} >= nr);
      lmgm_pkg::OP_COL: seq_err = ({1'b0, col_q[5:3]} >= nc);
      default:          seq_err = 1'b1;
    endcase
    if (seq_err || op_q == lmgm_pkg::OP_LED) begin
      beats_m1 = 3'd0;
    end else if (op_q == lmgm_pkg::OP_ROW) begin
      beats_m1 = 3'(nc - 4'd1);
    end else begin
      beats_m1 = nr - 3'd1;
    end
  end

  assign last_beat = (idx_q == beats_m1);
  assign busy_o    = seq_vld_q && !last_beat;
  assign accept    = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (accept) begin
      seq_vld_q <= 1'b1;
      idx_q     <= '0;
    end else if (seq_vld_q) begin
      if (last_beat) begin
        seq_vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= lmgm_pkg::opcode_e'(opcode_i);
      row_q   <= row_index_i;
      col_q   <= col_index_i;
      led_q   <= led_on_i;
      bytes_q <= line_bytes_i;
    end
  end

  // stage a: serpentine tile address and data byte of the current beat
  always_comb begin
    rb = row_q[4:3];
    cb = col_q[5:3];
    if (op_q == lmgm_pkg::OP_ROW) begin
      cb = idx_q;
    end else if (op_q == lmgm_pkg::OP_COL) begin
      rb = idx_q[1:0];
    end
    // odd tile rows run right to left
    cpos      = rb[0] ? 3'(nc - 4'd1 - {1'b0, cb}) : cb;
    tile_base = {3'b0, rb} * {1'b0, nc};

    beat_a_d      = '0;
    beat_a_d.vld  = seq_vld_q;
    beat_a_d.err  = seq_err;
    beat_a_d.op   = op_q;
    beat_a_d.tile = tile_base + {2'b0, cpos};
    beat_a_d.r    = row_q[2:0];
    beat_a_d.c    = col_q[2:0];
    beat_a_d.led  = led_q;
    beat_a_d.pat  = bytes_q[{idx_q, 3'b000} +: 8];
    beat_a_d.last = last_beat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_a_q <= '0;
      beat_b_q <= '0;
    end else begin
      beat_a_q <= beat_a_d;
      beat_b_q <= beat_a_q;
    end
  end

  // stage b: rotation of the addressed tile
  always_ff @(posedge clk_i) begin
    rot_b_q <= rot_map_q[{beat_a_q.tile, 1'b0} +: 2];
  end

  // stage c: local coordinates and data byte after rotation
  lmgm_rotate u_rotate (
    .beat_i (beat_b_q),
    .rot_i  (rot_b_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= beat_b_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_vld_q;
  assign tile_number_o  = res_q.tile;
  assign command_kind_o = res_q.kind;
  assign line_select_o  = res_q.line;
  assign bit_select_o   = res_q.bit_sel;
  assign pattern_byte_o = res_q.pat;
  assign out_of_range_o = res_q.err;
  assign last_of_run_o  = res_q.last;

  assign err_beat_clean = last_of_run_o && tile_number_o == 5'd0 &&
                          command_kind_o == lmgm_pkg::KIND_LED && line_select_o == 3'd0 &&
                          bit_select_o == 3'd0 && pattern_byte_o == 8'd0;
  assign led_beat       = result_valid_o && !out_of_range_o &&
                          command_kind_o == lmgm_pkg::KIND_LED;

`include "led_matrix_grid_mapper_assert.svh"

  // an error beat carries nothing but the error and last flags
  `LMGM_ASSERT(a_err_clean, result_valid_o && out_of_range_o |-> err_beat_clean, "dirty error beat")

  // a taken command shows its first result after the sequencer, tile address, rotation and output registers
  `LMGM_ASSERT(a_latency, accept |-> ##4 result_valid_o, "missing first result beat")

  // a single led command is always a one-beat run
  `LMGM_ASSERT(a_led_single, led_beat |-> last_of_run_o, "single led beat not last")

  // busy only while the sequencer holds a command
  `LMGM_ASSERT_ALWAYS(a_busy_seq, busy_o |-> seq_vld_q, "busy with idle sequencer")

endmodule

`default_nettype wire
